// ===== rtl/core/vcs_pkg.sv =====
// Package for the one-wire voice chip command sender.
// Holds the queue entry and configuration types, the register indexes,
// the frame phase numbers and the request-to-code table. No dependencies.
package vcs_pkg;

  localparam int unsigned REQ_W   = 8;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned REG_W   = 8;
  localparam int unsigned IDX_W   = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PRE_HIGH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RESET_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_POST_RESET = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_LOW  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LONG       = 3'd4;
  localparam logic [IDX_W-1:0] REG_SHORT      = 3'd5;
  localparam logic [IDX_W-1:0] REG_TAIL       = 3'd6;

  // Register values after reset.
  localparam logic [REG_W-1:0] RST_PRE_HIGH   = 8'd5;
  localparam logic [REG_W-1:0] RST_RESET_LOW  = 8'd5;
  localparam logic [REG_W-1:0] RST_POST_RESET = 8'd60;
  localparam logic [REG_W-1:0] RST_START_LOW  = 8'd5;
  localparam logic [REG_W-1:0] RST_LONG       = 8'd3;
  localparam logic [REG_W-1:0] RST_SHORT      = 8'd1;
  localparam logic [REG_W-1:0] RST_TAIL       = 8'd20;

  // Frame phases.
  localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
  localparam logic [PHASE_W-1:0] PH_PRE_HIGH   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_RESET_LOW  = 5'd2;
  localparam logic [PHASE_W-1:0] PH_POST_RESET = 5'd3;
  localparam logic [PHASE_W-1:0] PH_START_LOW  = 5'd4;
  localparam logic [PHASE_W-1:0] PH_BIT_FIRST  = 5'd5;
  localparam logic [PHASE_W-1:0] PH_BIT_LAST   = 5'd20;
  localparam logic [PHASE_W-1:0] PH_TAIL_LOAD  = 5'd21;
  localparam logic [PHASE_W-1:0] PH_TAIL       = 5'd22;

  typedef struct packed {
    logic [REG_W-1:0] pre_high_ms;
    logic [REG_W-1:0] reset_low_ms;
    logic [REG_W-1:0] post_reset_ms;
    logic [REG_W-1:0] start_low_ms;
    logic [REG_W-1:0] long_ms;
    logic [REG_W-1:0] short_ms;
    logic [REG_W-1:0] tail_ms;
  } cfg_regs_t;

  // One classified word from the front end.
  typedef struct packed {
    logic              tick;
    logic              take;
    logic [CODE_W-1:0] code;
  } q_entry_t;

  function automatic logic [CODE_W-1:0] req_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      3'd0:    c = 4'h0;
      3'd1:    c = 4'h1;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h3;
      3'd4:    c = 4'h5;
      3'd5:    c = 4'h6;
      3'd6:    c = 4'h7;
      default: c = 4'h8;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/vcs_front.sv =====
// Front end: latches prompt requests as pending and, on a tick, picks the
// highest-priority one and turns it into a command code. Uses vcs_pkg.
module vcs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic                        tick,
  input  logic [vcs_pkg::REQ_W-1:0]   new_requests,
  output vcs_pkg::q_entry_t           entry
);

  logic [vcs_pkg::REQ_W-1:0] pending_r, pending_nxt;
  logic [vcs_pkg::REQ_W-1:0] merged;
  logic [vcs_pkg::REQ_W-1:0] lowest;
  logic [vcs_pkg::IDX_W-1:0] pick_idx;

  assign merged = pending_r | new_requests;
  // Isolate the lowest set bit: bit 0 has the highest priority.
  assign lowest = merged & (~merged + vcs_pkg::REQ_W'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < vcs_pkg::REQ_W; i++) begin
      if (lowest[i]) begin
        pick_idx = vcs_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    entry.tick  = tick;
    entry.take  = tick && (merged != '0);
    entry.code  = vcs_pkg::req_code(pick_idx);
    pending_nxt = tick ? (merged & ~lowest) : merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (acc) begin
      pending_r <= pending_nxt;
    end
  end

endmodule

// ===== rtl/core/vcs_queue.sv =====
// Short FIFO of classified words between the front end and the sequencer.
// Push and pop may happen in the same cycle. Uses vcs_pkg.
module vcs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vcs_pkg::q_entry_t wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output vcs_pkg::q_entry_t rd_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vcs_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_entry  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/vcs_back.sv =====
// Back end: frame sequencer that steps the pin levels once per tick word
// and holds the result word in an output register. Uses vcs_pkg.
module vcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  vcs_pkg::cfg_regs_t cfg,
  input  logic               q_valid,
  input  vcs_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               rst_pin,
  output logic               data_pin,
  output logic               busy_res
);

  logic [vcs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [vcs_pkg::CNT_W-1:0]   countdown_r, countdown_nxt;
  logic [vcs_pkg::CODE_W-1:0]  command_r, command_nxt;
  logic active_r, active_nxt;
  logic rst_level_r, rst_level_nxt;
  logic data_level_r, data_level_nxt;
  logic out_valid_r;
  logic rst_pin_r, data_pin_r, busy_r;
  logic [vcs_pkg::PHASE_W-1:0] odd_off, even_off;
  logic odd_bit, even_bit;

  // Command bits 4..7 go out as zeros.
  function automatic logic cmd_bit(input logic [vcs_pkg::CODE_W-1:0] cmd,
                                   input logic [vcs_pkg::PHASE_W-2:0] idx);
    logic b;
    b = (idx > 4'd3) ? 1'b0 : cmd[idx[1:0]];
    return b;
  endfunction

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt      = phase_r;
    countdown_nxt  = countdown_r;
    command_nxt    = command_r;
    active_nxt     = active_r;
    rst_level_nxt  = rst_level_r;
    data_level_nxt = data_level_r;
    odd_off        = phase_r - vcs_pkg::PH_BIT_FIRST;
    even_off       = phase_r - vcs_pkg::PH_START_LOW;
    if (q_entry.take) begin
      command_nxt = q_entry.code;
    end
    odd_bit  = cmd_bit(command_nxt, odd_off[vcs_pkg::PHASE_W-1:1]);
    even_bit = cmd_bit(command_nxt, even_off[vcs_pkg::PHASE_W-1:1]);
    if (q_pop && q_entry.tick) begin
      if (countdown_r != '0) begin
        countdown_nxt = countdown_r - vcs_pkg::CNT_W'(1);
      end
      active_nxt = active_r | q_entry.take;
      if (active_nxt) begin
        if (phase_r == vcs_pkg::PH_IDLE) begin
          phase_nxt     = vcs_pkg::PH_PRE_HIGH;
          countdown_nxt = cfg.pre_high_ms;
        end else if (phase_r == vcs_pkg::PH_PRE_HIGH) begin
          rst_level_nxt  = 1'b1;
          data_level_nxt = 1'b1;
          if (countdown_nxt == '0) begin
            phase_nxt     = vcs_pkg::PH_RESET_LOW;
            countdown_nxt = cfg.reset_low_ms;
          end
        end else if (phase_r == vcs_pkg::PH_RESET_LOW) begin
          rst_level_nxt  = 1'b0;
          data_level_nxt = 1'b1;
          if (countdown_nxt == '0) begin
            phase_nxt     = vcs_pkg::PH_POST_RESET;
            countdown_nxt = cfg.post_reset_ms;
          end
        end else if (phase_r == vcs_pkg::PH_POST_RESET) begin
          rst_level_nxt  = 1'b1;
          data_level_nxt = 1'b1;
          if (countdown_nxt == '0) begin
            phase_nxt     = vcs_pkg::PH_START_LOW;
            countdown_nxt = cfg.start_low_ms;
          end
        end else if (phase_r == vcs_pkg::PH_START_LOW) begin
          rst_level_nxt  = 1'b1;
          data_level_nxt = 1'b0;
          if (countdown_nxt == '0) begin
            phase_nxt     = vcs_pkg::PH_BIT_FIRST;
            countdown_nxt = command_nxt[0] ? cfg.long_ms : cfg.short_ms;
          end
        end else if (phase_r >= vcs_pkg::PH_BIT_FIRST && phase_r <= vcs_pkg::PH_BIT_LAST) begin
          rst_level_nxt = 1'b1;
          if (phase_r[0]) begin
            // High part of the current bit; the low part follows.
            data_level_nxt = 1'b1;
            if (countdown_nxt == '0) begin
              phase_nxt     = phase_r + vcs_pkg::PHASE_W'(1);
              countdown_nxt = odd_bit ? cfg.short_ms : cfg.long_ms;
            end
          end else begin
            // Low part of the current bit; load the next bit's high part.
            data_level_nxt = 1'b0;
            if (countdown_nxt == '0) begin
              phase_nxt     = phase_r + vcs_pkg::PHASE_W'(1);
              countdown_nxt = even_bit ? cfg.long_ms : cfg.short_ms;
            end
          end
        end else if (phase_r == vcs_pkg::PH_TAIL_LOAD) begin
          rst_level_nxt  = 1'b1;
          data_level_nxt = 1'b1;
          countdown_nxt  = cfg.tail_ms;
          phase_nxt      = vcs_pkg::PH_TAIL;
        end else if (phase_r == vcs_pkg::PH_TAIL) begin
          rst_level_nxt  = 1'b1;
          data_level_nxt = 1'b1;
          if (countdown_nxt == '0) begin
            phase_nxt  = vcs_pkg::PH_IDLE;
            active_nxt = 1'b0;
          end
        end else begin
          phase_nxt  = vcs_pkg::PH_IDLE;
          active_nxt = 1'b0;
        end
      end
    end else if (!q_pop) begin
      command_nxt = command_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= vcs_pkg::PH_IDLE;
      countdown_r  <= '0;
      command_r    <= '0;
      active_r     <= 1'b0;
      rst_level_r  <= 1'b0;
      data_level_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r      <= phase_nxt;
        countdown_r  <= countdown_nxt;
        command_r    <= command_nxt;
        active_r     <= active_nxt;
        rst_level_r  <= rst_level_nxt;
        data_level_r <= data_level_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rst_pin_r  <= rst_level_nxt;
      data_pin_r <= data_level_nxt;
      busy_r     <= active_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rst_pin   = rst_pin_r;
  assign data_pin  = data_pin_r;
  assign busy_res  = busy_r;

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (phase_r == vcs_pkg::PH_IDLE))
    else $error("sequencer idle but phase not at frame start");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= vcs_pkg::PH_TAIL)
    else $error("sequencer phase beyond tail");

  // A request taken in the last tail tick may end the frame in the same step.
  a_take_active: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.take && (phase_r != vcs_pkg::PH_TAIL)) |=> active_r)
    else $error("taken request did not start a frame");

  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("word popped while result register stalled");

endmodule

// ===== rtl/core/voice_chip_one_wire_command_sender_top.sv =====
// Top level of the one-wire voice chip command sender.
// Holds the configuration registers and ties vcs_front, vcs_queue and
// vcs_back together. Uses vcs_pkg.

// Each input word carries a tick flag and eight prompt request bits; every
// word yields exactly one result word with the reset line level, the data
// line level and a busy flag. The block takes one word per clock cycle
// while the queue has room: the front end latches and prioritizes requests
// in the accepting cycle, the word then waits in a small queue
// (QUEUE_DEPTH entries), and the sequencer pops it, updates its phase and
// countdown and loads the output register. A stalled output fills the
// queue, after which in_tready drops.
// Configuration registers (index, reset value, in ticks): 0 pre-high (5),
// 1 reset-low (5), 2 post-reset idle (60), 3 start mark (5), 4 long bit
// phase (3), 5 short bit phase (1), 6 tail (20); writes to index 7 are
// ignored. cfg_ready is always high; write only while the block is idle.
module voice_chip_one_wire_command_sender_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] tick, [8:1] new_requests, [15:9] zero
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] rst_pin, [1] data_pin, [2] busy_res, [7:3] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  vcs_pkg::cfg_regs_t cfg_r;
  vcs_pkg::q_entry_t  front_entry, back_entry;
  logic in_acc;
  logic q_full, q_not_empty, q_pop;
  logic rst_pin, data_pin, busy_res;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_high_ms   <= vcs_pkg::RST_PRE_HIGH;
      cfg_r.reset_low_ms  <= vcs_pkg::RST_RESET_LOW;
      cfg_r.post_reset_ms <= vcs_pkg::RST_POST_RESET;
      cfg_r.start_low_ms  <= vcs_pkg::RST_START_LOW;
      cfg_r.long_ms       <= vcs_pkg::RST_LONG;
      cfg_r.short_ms      <= vcs_pkg::RST_SHORT;
      cfg_r.tail_ms       <= vcs_pkg::RST_TAIL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcs_pkg::REG_PRE_HIGH:   cfg_r.pre_high_ms   <= cfg_data;
        vcs_pkg::REG_RESET_LOW:  cfg_r.reset_low_ms  <= cfg_data;
        vcs_pkg::REG_POST_RESET: cfg_r.post_reset_ms <= cfg_data;
        vcs_pkg::REG_START_LOW:  cfg_r.start_low_ms  <= cfg_data;
        vcs_pkg::REG_LONG:       cfg_r.long_ms       <= cfg_data;
        vcs_pkg::REG_SHORT:      cfg_r.short_ms      <= cfg_data;
        vcs_pkg::REG_TAIL:       cfg_r.tail_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // A word is accepted whenever the queue has room.
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  vcs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .tick         (in_tdata[0]),
    .new_requests (in_tdata[8:1]),
    .entry        (front_entry)
  );

  vcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .wr_entry  (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (back_entry)
  );

  vcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_entry   (back_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rst_pin   (rst_pin),
    .data_pin  (data_pin),
    .busy_res  (busy_res)
  );

  assign out_tdata = {5'b0, busy_res, data_pin, rst_pin};

endmodule
